// ----- sv/rse_pkg.sv -----
// Ribbon strip extrusion: shared types and constants.
// No dependencies.
`timescale 1ns / 1ps
package rse_pkg;
	localparam int unsigned CfgIdxW = 1;
	localparam logic [CfgIdxW-1:0] CFG_TEX_LEN = 1'd0;
	localparam logic [CfgIdxW-1:0] CFG_SCALE = 1'd1;
	localparam logic [30:0] TEX_LEN_RST = 31'd4194304;
	localparam logic [15:0] SCALE_RST = 16'd256;

	typedef struct packed {
		logic [31:0] ry;
		logic [31:0] rx;
		logic [31:0] ly;
		logic [31:0] lx;
	} edge_t;

	function automatic logic [31:0] sat32(input logic signed [40:0] v);
		if (v > 41'sd2147483647) return 32'h7FFFFFFF;
		if (v < -41'sd2147483648) return 32'h80000000;
		return v[31:0];
	endfunction
endpackage

// ----- sv/ribbon_strip_extrusion.sv -----
// Ribbon strip extrusion top level: point intake, shared sqrt/divide unit,
// edge assembly and output register. Depends on rse_pkg.
`timescale 1ns / 1ps
// Usage:
//  s_axis_*: one path point per request. tdata = {full_width, pos_y, pos_x}
//  (pos_x lowest), zero padded to 96 bits.
//  m_axis_*: edge pairs. tdata = {tex_v, right_y, right_x, left_y, left_x},
//  tuser = strip_start, tlast = last result of the point.
//  cfg_*: index 0 texture_length, index 1 content_scale, taken when cfg_we.
// Timing: one point at a time. Scaling and saturation (ST_SCALE, ST_SAT), then
// squaring on the shared multiplier, a bit-serial square root (33 steps), a
// bit-serial v divide (64 steps) and two bit-serial offset divides (64 steps
// each), four for a leading edge, all on one shared shift/subtract unit,
// then the edges one at a time and a release state. Offsets are skipped at
// zero length. Receiver stalls add to the busy time. The first point only stores.
// Reset clears state to the start of a new ribbon and restores register
// defaults. A stalled receiver holds the output register; the block waits
// and accepts nothing new until every edge of the point is taken.
module ribbon_strip_extrusion
	import rse_pkg::*;
#(
	parameter int unsigned STRIP_EDGES = 50
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [95:0]  s_axis_tdata,  // pos_x, pos_y, full_width, pad
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [159:0] m_axis_tdata,  // left_x, left_y, right_x, right_y, tex_v
	output logic         m_axis_tuser,  // strip_start
	output logic         m_axis_tlast,
	input  logic         cfg_we,
	input  logic [CfgIdxW-1:0] cfg_idx,
	input  logic [30:0]  cfg_data
);
	localparam int unsigned CntW = $clog2(STRIP_EDGES + 2);

	localparam logic [3:0] ST_IDLE = 4'd0, ST_SCALE = 4'd1, ST_SQ = 4'd2,
		ST_SQRT = 4'd3, ST_VDIV = 4'd4, ST_ODIV = 4'd5, ST_EDGE = 4'd6,
		ST_OUT = 4'd7, ST_SAT = 4'd8;

	logic [3:0] state_q;
	logic [30:0] tex_len_q;
	logic [15:0] scale_q;
	logic started_q;
	logic [31:0] prev_x_q, prev_y_q, tex_pos_q;
	logic [29:0] prev_hw_q;
	logic [CntW-1:0] cnt_q;
	edge_t prev_edge_q;

	logic signed [31:0] in_x_q, in_y_q;
	logic [29:0] hw_q;
	logic signed [48:0] px_q, py_q;
	logic [31:0] x_q, y_q;
	logic signed [32:0] dx_q, dy_q;
	logic [32:0] ax_q, ay_q;
	logic [65:0] sq_q;
	logic [65:0] rem_q;
	logic [32:0] root_q;
	logic [6:0] step_q;
	logic [63:0] num_q, quo_q;
	logic [32:0] div_q;
	logic [1:0] oidx_q;
	logic [31:0] off_q [4];
	logic [31:0] tend_q;
	logic lead_q, phase_q;

	// shared shift/subtract step
	logic [65:0] trial, rem_sh, rem_nx;
	logic take;
	always_comb begin
		trial = '0;
		rem_sh = '0;
		if (state_q == ST_SQRT) begin
			rem_sh = {rem_q[63:0], sq_q[65:64]};
			trial = {31'd0, root_q, 2'b01};
		end else begin
			rem_sh = {rem_q[64:0], num_q[63]};
			trial = {33'd0, div_q};
		end
		take = rem_sh >= trial;
		rem_nx = take ? rem_sh - trial : rem_sh;
	end

	// shared multiplier: squares, then next offset numerator w * |d|
	logic [1:0] nk;
	logic [29:0] ow;
	logic [32:0] od;
	logic [32:0] ma, mb;
	logic [65:0] prod;
	always_comb begin
		nk = (state_q == ST_VDIV) ? (cnt_q == '0 ? 2'd0 : 2'd2) : oidx_q + 2'd1;
		ow = nk[1] ? hw_q : prev_hw_q;
		od = nk[0] ? ax_q : ay_q;
		if (state_q == ST_SQ) begin
			ma = (step_q == 7'd1) ? ax_q : ay_q;
			mb = ma;
		end else begin
			ma = od;
			mb = {3'd0, ow};
		end
		prod = 66'(ma) * 66'(mb);
	end

	function automatic logic [31:0] neg32(input logic [31:0] v, input logic n);
		return n ? -v : v;
	endfunction

	edge_t cur_e;
	logic signed [35:0] bx, by;
	logic signed [35:0] ox, oy;
	logic [29:0] ew;
	always_comb begin
		bx = lead_q ? 36'(signed'(prev_x_q)) : 36'(signed'(x_q));
		by = lead_q ? 36'(signed'(prev_y_q)) : 36'(signed'(y_q));
		ew = lead_q ? prev_hw_q : hw_q;
		if (root_q == '0) begin
			ox = '0;
			oy = -36'(ew);
		end else begin
			ox = 36'(signed'(neg32(off_q[{~lead_q, 1'b0}], dy_q[32])));
			oy = -36'(signed'(neg32(off_q[{~lead_q, 1'b1}], dx_q[32])));
		end
		cur_e.lx = sat32(41'(bx + ox));
		cur_e.ly = sat32(41'(by + oy));
		cur_e.rx = sat32(41'(bx - ox));
		cur_e.ry = sat32(41'(by - oy));
	end

	assign s_axis_tready = state_q == ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tex_len_q <= TEX_LEN_RST;
			scale_q <= SCALE_RST;
			started_q <= 1'b0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_hw_q <= '0;
			tex_pos_q <= '0;
			cnt_q <= '0;
			prev_edge_q <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_TEX_LEN: tex_len_q <= cfg_data;
					CFG_SCALE: scale_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: if (s_axis_tvalid) begin
					in_x_q <= s_axis_tdata[31:0];
					in_y_q <= s_axis_tdata[63:32];
					hw_q <= s_axis_tdata[94:65];
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					px_q <= in_x_q * $signed({1'b0, scale_q});
					py_q <= in_y_q * $signed({1'b0, scale_q});
					state_q <= ST_SAT;
				end
				ST_SAT: begin
					x_q <= sat32(41'(px_q >>> 8));
					y_q <= sat32(41'(py_q >>> 8));
					if (!started_q) begin
						prev_x_q <= sat32(41'(px_q >>> 8));
						prev_y_q <= sat32(41'(py_q >>> 8));
						prev_hw_q <= hw_q;
						started_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						dx_q <= 33'(signed'(prev_x_q)) - 33'(signed'(sat32(41'(px_q >>> 8))));
						dy_q <= 33'(signed'(prev_y_q)) - 33'(signed'(sat32(41'(py_q >>> 8))));
						state_q <= ST_SQ;
						step_q <= '0;
					end
				end
				ST_SQ: begin
					// two squares, one after the other, on one multiplier
					if (step_q == '0) begin
						ax_q <= dx_q[32] ? -dx_q : dx_q;
						ay_q <= dy_q[32] ? -dy_q : dy_q;
						step_q <= 7'd1;
					end else if (step_q == 7'd1) begin
						sq_q <= prod;
						step_q <= 7'd2;
					end else begin
						sq_q <= sq_q + prod;
						rem_q <= '0;
						root_q <= '0;
						step_q <= 7'd32;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					rem_q <= rem_nx;
					root_q <= {root_q[31:0], take};
					sq_q <= {sq_q[63:0], 2'b00};
					if (step_q == '0) begin
						rem_q <= '0;
						num_q <= {15'd0, root_q[31:0], take, 16'd0};
						div_q <= (tex_len_q == '0) ? 33'd1 : {2'b0, tex_len_q};
						step_q <= 7'd63;
						state_q <= ST_VDIV;
					end else
						step_q <= step_q - 7'd1;
				end
				ST_VDIV, ST_ODIV: begin
					rem_q <= rem_nx;
					num_q <= {num_q[62:0], 1'b0};
					quo_q <= {quo_q[62:0], take};
					if (step_q != '0)
						step_q <= step_q - 7'd1;
					else begin
						if (state_q == ST_VDIV)
							tend_q <= tex_pos_q + {quo_q[30:0], take};
						else
							off_q[oidx_q] <= {quo_q[30:0], take};
						if (state_q == ST_ODIV && oidx_q == 2'd3 || root_q == '0)
							state_q <= ST_EDGE;
						else begin
							oidx_q <= nk;
							num_q <= prod[63:0];
							div_q <= root_q;
							rem_q <= '0;
							step_q <= 7'd63;
							state_q <= ST_ODIV;
						end
					end
					lead_q <= cnt_q == '0;
					phase_q <= 1'b0;
				end
				ST_EDGE: begin
					if (!m_axis_tvalid || m_axis_tready) begin
						m_axis_tvalid <= 1'b1;
						if (!phase_q && (cnt_q == '0 || cnt_q >= CntW'(STRIP_EDGES))) begin
							m_axis_tdata <= {tex_pos_q, cnt_q == '0 ? cur_e : prev_edge_q};
							m_axis_tuser <= 1'b1;
							m_axis_tlast <= 1'b0;
							cnt_q <= CntW'(1);
							lead_q <= 1'b0;
							phase_q <= 1'b1;
						end else begin
							m_axis_tdata <= {tend_q, cur_e};
							m_axis_tuser <= 1'b0;
							m_axis_tlast <= 1'b1;
							prev_edge_q <= cur_e;
							cnt_q <= cnt_q + CntW'(1);
							tex_pos_q <= tend_q;
							prev_x_q <= x_q;
							prev_y_q <= y_q;
							prev_hw_q <= hw_q;
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: if (m_axis_tready) begin
					m_axis_tvalid <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (m_axis_tvalid && m_axis_tready && state_q != ST_OUT && state_q != ST_EDGE)
				m_axis_tvalid <= 1'b0;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid || state_q == ST_IDLE)
		else $error("input taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> !s_axis_tready)
		else $error("ready while last edge pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> !m_axis_tlast)
		else $error("strip start marked last");
endmodule
